>>> src/order_preserving_dedupe_filter_defines.svh
// assertion macros for the order preserving dedupe filter
// used by the checker module; no other dependencies
`ifndef ORDER_PRESERVING_DEDUPE_FILTER_DEFINES_SVH
`define ORDER_PRESERVING_DEDUPE_FILTER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ODF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ODF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define ODF_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/odf_pkg.sv
// shared types and constants of the order preserving dedupe filter
// no dependencies
package odf_pkg;

    localparam int ID_W        = 16;
    localparam int EPOCH_BITS  = 8;
    localparam int Q_DEPTH     = 3;
    localparam int Q_CW        = 2;

    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};

    typedef enum logic {
        MODE_CLEAR,
        MODE_RUN
    } t_mode;

    typedef struct packed {
        logic [ID_W-1:0] out_id;
        logic            keep;
        logic            out_last;
    } t_result;

endpackage

>>> src/odf_if.sv
// valid/ready channel interfaces for input and result items
// depends on odf_pkg
interface odf_in_if;
    import odf_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] node_id;
    logic            end_of_list;

    modport source (output valid, output node_id, output end_of_list, input ready);
    modport sink   (input valid, input node_id, input end_of_list, output ready);
endinterface

interface odf_out_if;
    import odf_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] out_id;
    logic            keep;
    logic            out_last;

    modport source (output valid, output out_id, output keep, output out_last, input ready);
    modport sink   (input valid, input out_id, input keep, input out_last, output ready);
endinterface

>>> src/odf_tag_ram.sv
// single-port-write, single-port-read tag memory with a registered read
// no dependencies
module odf_tag_ram #(
    parameter int AW = 16,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/odf_outq.sv
// three-entry result queue that drives the output channel
// depends on odf_pkg and odf_out_if
module odf_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  odf_pkg::t_result     i_data,
    output logic [odf_pkg::Q_CW-1:0] o_count,
    odf_out_if.source            o_out
);
    import odf_pkg::*;

    t_result           r_mem [Q_DEPTH];
    logic [Q_CW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_CW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]   r_count, n_count;
    logic              pop;
    t_result           head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_CW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_CW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_count        = r_count;
    assign o_out.valid    = (r_count != '0);
    assign o_out.out_id   = head.out_id;
    assign o_out.keep     = head.keep;
    assign o_out.out_last = head.out_last;

endmodule

>>> src/order_preserving_dedupe_filter.sv
// a result is offered once its item has left the lookup stage for the result queue
// throughput: one item per cycle while the queue has room, set by the single tag
// memory read and write port; reset and every 255th list end start a clearing pass
// that writes one tag entry per cycle; no item is accepted meanwhile
// depends on odf_pkg, odf_if, odf_tag_ram and odf_outq
module order_preserving_dedupe_filter #(
    parameter int ID_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    odf_in_if.sink    i_in,
    odf_out_if.source o_out
);
    import odf_pkg::*;

    localparam int AW = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    // list epoch and clearing sequencer
    t_mode                 r_mode, n_mode;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;

    // lookup stage
    logic                  r_s1_valid;
    logic [ID_W-1:0]       r_s1_id;
    logic                  r_s1_last;
    logic [AW-1:0]         s1_addr;

    // forwarding of the write made in the cycle of the read
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    logic [EPOCH_BITS-1:0] r_fwd_tag;

    logic                  accept;
    logic                  wrap_block;
    logic [Q_CW-1:0]       q_count;
    logic [Q_CW:0]         q_load;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EPOCH_BITS-1:0] ram_wdata;
    logic [EPOCH_BITS-1:0] ram_rdata;
    logic [EPOCH_BITS-1:0] cur_tag;
    t_result               s1_res;

    assign s1_addr = r_s1_id[AW-1:0];

    // hold off input while the last list of an epoch run sits in lookup
    assign wrap_block = r_s1_valid && r_s1_last && (r_epoch == EPOCH_MAX);
    assign q_load     = {1'b0, q_count} + {{Q_CW{1'b0}}, r_s1_valid};
    assign i_in.ready = (r_mode == MODE_RUN) && !wrap_block && (q_load < (Q_CW+1)'(Q_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    // sequencer next state
    always_comb begin
        n_mode     = r_mode;
        n_clr_addr = r_clr_addr;
        n_epoch    = r_epoch;
        case (r_mode)
            MODE_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_mode = MODE_RUN;
                end
            end
            MODE_RUN: begin
                if (r_s1_valid && r_s1_last) begin
                    if (r_epoch == EPOCH_MAX) begin
                        n_epoch = EPOCH_FIRST;
                        n_mode  = MODE_CLEAR;
                    end else begin
                        n_epoch = r_epoch + 1'b1;
                    end
                end
            end
            default: begin
                n_mode = MODE_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
        end else begin
            r_mode     <= n_mode;
            r_clr_addr <= n_clr_addr;
            r_epoch    <= n_epoch;
        end
    end

    // lookup stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_fwd_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_id   <= i_in.node_id;
            r_s1_last <= i_in.end_of_list;
        end
        r_fwd_addr <= s1_addr;
        r_fwd_tag  <= r_epoch;
    end

    // tag write: clearing pass or test-and-set of the item in lookup
    always_comb begin
        ram_we    = r_s1_valid;
        ram_waddr = s1_addr;
        ram_wdata = r_epoch;
        if (r_mode == MODE_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end
    end

    odf_tag_ram #(
        .AW (AW),
        .DW (EPOCH_BITS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_in.node_id[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // seen test with the previous item's write forwarded
    assign cur_tag = (r_fwd_valid && (r_fwd_addr == s1_addr)) ? r_fwd_tag : ram_rdata;

    always_comb begin
        s1_res.out_id   = r_s1_id;
        s1_res.keep     = (cur_tag != r_epoch);
        s1_res.out_last = r_s1_last;
    end

    odf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_res),
        .o_count (q_count),
        .o_out   (o_out)
    );

endmodule

>>> src/odf_checker.sv
// port-level checks of the order preserving dedupe filter, bound to the top level
// depends on odf_pkg, odf_if and the assertion macro header
`include "order_preserving_dedupe_filter_defines.svh"

module odf_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    odf_in_if.sink    i_in,
    odf_out_if.source o_out
);
    import odf_pkg::*;

    logic            in_acc;
    logic            out_acc;
    logic [2:0]      r_outstanding;
    logic            r_list_start;
    logic            r_prev_valid;
    logic [ID_W-1:0] r_prev_id;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + {2'b0, in_acc} - {2'b0, out_acc};
        end
    end

    // track list start and the previous delivered item of the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_start <= 1'b1;
            r_prev_valid <= 1'b0;
        end else if (out_acc) begin
            r_list_start <= o_out.out_last;
            r_prev_valid <= !o_out.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev_id <= o_out.out_id;
        end
    end

    `ODF_ASSERT_RST(a_no_out_after_rst, i_clk, !i_rst_n, !o_out.valid, "result after reset")
    `ODF_ASSERT_IMPL(a_first_kept, i_clk, i_rst_n, o_out.valid && r_list_start, o_out.keep, "first item of list not kept")
    `ODF_ASSERT_IMPL(a_repeat_dropped, i_clk, i_rst_n, o_out.valid && r_prev_valid && (o_out.out_id == r_prev_id), !o_out.keep, "repeated id kept")
    `ODF_ASSERT_IMPL(a_no_phantom, i_clk, i_rst_n, o_out.valid, (r_outstanding != 3'd0) && (r_outstanding <= 3'd3), "result without item or too many in flight")
    `ODF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.out_id) && $stable(o_out.keep), "stalled result changed")

endmodule

bind order_preserving_dedupe_filter odf_checker u_odf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

>>> test/odf_dedupe_checker.sv
// result checker for the order preserving dedupe filter testbench
// watches the item and result channels, predicts every result and compares in order
// depends on odf_pkg and the channel interfaces in odf_if
module odf_dedupe_checker #(
    parameter int ID_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    odf_in_if    i_in_mon,
    odf_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import odf_pkg::*;

    // identifiers are tracked by their low bits only when ID_BITS is narrow
    localparam int TRACK_BITS = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam logic [ID_W-1:0] TRACK_MASK = ID_W'((1 << TRACK_BITS) - 1);

    // a slot counts as seen when its stamp equals the current list number
    int unsigned list_stamp [0:(1 << TRACK_BITS)-1];
    int unsigned list_number = 1;
    t_result     expected_results [$];
    int          fail_total = 0;

    // first-occurrence test and mark, advancing the list on its last item
    function automatic t_result dedupe_predict(input logic [ID_W-1:0] id, input logic last);
        t_result     res;
        int unsigned slot;
        slot         = int'(id & TRACK_MASK);
        res.out_id   = id;
        res.keep     = (list_stamp[slot] != list_number);
        res.out_last = last;
        list_stamp[slot] = list_number;
        if (last)
            list_number++;
        return res;
    endfunction

    // predict on accepted items, compare on accepted results
    always @(posedge i_clk) begin
        t_result want;
        t_result predicted;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                predicted = dedupe_predict(i_in_mon.node_id, i_in_mon.end_of_list);
                expected_results.insert(expected_results.size(), predicted);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: out_id %0h keep %0b out_last %0b",
                           i_out_mon.out_id, i_out_mon.keep, i_out_mon.out_last);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_mon.out_id !== want.out_id) begin
                        $error("out_id mismatch: expected %0h, actual %0h",
                               want.out_id, i_out_mon.out_id);
                        fail_total++;
                    end
                    if (i_out_mon.keep !== want.keep) begin
                        $error("keep mismatch: expected %0b, actual %0b",
                               want.keep, i_out_mon.keep);
                        fail_total++;
                    end
                    if (i_out_mon.out_last !== want.out_last) begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.out_last, i_out_mon.out_last);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

>>> test/tb.sv
// top of the order preserving dedupe filter testbench
// drives lists of identifiers and result backpressure, gives the verdict
// depends on odf_pkg, odf_if, the filter and odf_dedupe_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import odf_pkg::*;

    localparam int ID_BITS      = 16;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 500;
    localparam int POOL_SIZE    = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_granted   = 0;
    int hold_left      = 0;

    logic [ID_W-1:0] id_pool [POOL_SIZE];

    odf_in_if  in_ch ();
    odf_out_if out_ch ();

    order_preserving_dedupe_filter #(
        .ID_BITS(ID_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    odf_dedupe_checker #(
        .ID_BITS(ID_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    // clock
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // result side: long hold-offs on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_granted < hold_asked) begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_granted <= hold_granted + 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one item after a random gap, return once it is taken
    task automatic offer_item(input logic [ID_W-1:0] id, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.node_id     <= id;
        in_ch.end_of_list <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // mostly pooled identifiers so lists repeat, the rest fully random
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 70)
            return id_pool[$urandom_range(POOL_SIZE-1)];
        return ID_W'($urandom);
    endfunction

    // stimulus
    initial begin
        // bit 16 is the end-of-list mark
        logic [ID_W:0] directed [20];
        int phase;
        int sent;
        int len;
        int k;
        directed = '{
            17'h00000, 17'h0FFFF, 17'h00000, 17'h1FFFF,            // extremes, repeats
            17'h10000,                                             // single-element list
            17'h1FFFF, 17'h1FFFF, 17'h1FFFF,                       // repeated end marks
            17'h05555, 17'h0AAAA, 17'h05555, 17'h00001, 17'h00001,
            17'h08000, 17'h07FFF, 17'h1AAAA,                       // alternating bits
            17'h0002A, 17'h0002A, 17'h0002A, 17'h1002A             // one id over and over
        };
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.node_id     <= '0;
        in_ch.end_of_list <= 1'b0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            id_pool[k] = ID_W'($urandom);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lists
        for (k = 0; k < 20; k++)
            offer_item(directed[k][ID_W-1:0], directed[k][ID_W]);
        wait_drained();

        // random lists, one idling pattern per phase
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                    // receiver holds off while items keep coming
                    hold_asked <= hold_asked + 1;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 77;
                end
                default: begin
                    send_idle_pct = 6;
                    recv_stall_pct <= 6;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // many short lists so the list counter wraps and clearing passes run
                len = ($urandom_range(99) < 45) ? 1 : $urandom_range(2, 14);
                for (k = 0; k < len; k++)
                    offer_item(pick_id(), k == len - 1);
                sent += len;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
